>>> hw/rtl/bbpv_pkg.sv
// ----------------------------------------------------------------------------
// bbpv_pkg
// shared widths, multiplier operand codes and controller/datapath interface
// types for the bang-bang velocity controller
// ----------------------------------------------------------------------------
package bbpv_pkg;

  // motor count handling
  localparam int MAX_MOTORS  = 4;
  localparam int NUM_VEL     = 4;
  localparam int MOTOR_LIMIT = (MAX_MOTORS < NUM_VEL) ? MAX_MOTORS : NUM_VEL;

  // field widths
  localparam int TGT_W = 13;
  localparam int VEL_W = 8;
  localparam int DRV_W = 21;
  localparam int SPD_W = 32;
  localparam int CFG_W = 24;
  localparam int IDX_W = 3;
  localparam int CNT_W = 3;

  // stream packing
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  // drive limit, Q4.16 of 12 V
  localparam int VOLT_LIMIT = 786432;
  // ema weight 0.2 in Q0.16
  localparam int ALPHA_Q16  = 13107;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ACTIVE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IN_RCP  = 3'd1;
  localparam logic [IDX_W-1:0] REG_TGT_RCP = 3'd2;
  localparam logic [IDX_W-1:0] REG_KV      = 3'd3;
  localparam logic [IDX_W-1:0] REG_KP      = 3'd4;
  localparam logic [IDX_W-1:0] REG_KI      = 3'd5;
  localparam logic [IDX_W-1:0] REG_MARGIN  = 3'd6;

  // multiplier operand selection
  localparam logic [2:0] MUL_MEAS = 3'd0;
  localparam logic [2:0] MUL_EMA  = 3'd1;
  localparam logic [2:0] MUL_TGT  = 3'd2;
  localparam logic [2:0] MUL_KV   = 3'd3;
  localparam logic [2:0] MUL_KP   = 3'd4;
  localparam logic [2:0] MUL_KI   = 3'd5;

  typedef struct packed {
    logic       capture;
    logic       avg_en;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       ema_en;
    logic       tgt_en;
    logic       dec_en;
    logic       acc_load;
    logic       acc_add;
    logic       clamp_en;
    logic       out_load;
  } bbpv_cmd_t;

  typedef struct packed {
    logic bang;
  } bbpv_sts_t;

endpackage

>>> hw/rtl/bbpv_ctrl.sv
// ----------------------------------------------------------------------------
// bbpv_ctrl
// sequencer: steps the shared multiplier through one control tick and
// owns both stream handshakes
// ----------------------------------------------------------------------------
module bbpv_ctrl
  import bbpv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  bbpv_sts_t sts,
  output bbpv_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AVG   = 4'd1;
  localparam logic [3:0] S_MEAS  = 4'd2;
  localparam logic [3:0] S_EMA1  = 4'd3;
  localparam logic [3:0] S_EMA2  = 4'd4;
  localparam logic [3:0] S_TGT   = 4'd5;
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_MKV   = 4'd7;
  localparam logic [3:0] S_MKP   = 4'd8;
  localparam logic [3:0] S_MKI   = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;
  localparam logic [3:0] S_CLAMP = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = S_AVG;
      end
      S_AVG: begin
        cmd.avg_en = 1'b1;
        state_nxt  = S_MEAS;
      end
      S_MEAS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MEAS;
        state_nxt   = S_EMA1;
      end
      S_EMA1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_EMA;
        state_nxt   = S_EMA2;
      end
      S_EMA2: begin
        cmd.ema_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TGT;
        state_nxt   = S_TGT;
      end
      S_TGT: begin
        cmd.tgt_en = 1'b1;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        cmd.dec_en = 1'b1;
        state_nxt  = sts.bang ? S_OUT : S_MKV;
      end
      S_MKV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KV;
        state_nxt   = S_MKP;
      end
      S_MKP: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_KP;
        state_nxt    = S_MKI;
      end
      S_MKI: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KI;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted tick always starts the sequence
  a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_AVG)
    else $error("accepted tick did not start the sequence");

  // a result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while stalled");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

>>> hw/rtl/bbpv_dp.sv
// ----------------------------------------------------------------------------
// bbpv_dp
// datapath: configuration registers, reading average, shared multiplier,
// ema and integral state, accumulator, clamp and output register
// ----------------------------------------------------------------------------
module bbpv_dp
  import bbpv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic [TGT_W-1:0]        in_target,
  input  logic [NUM_VEL-1:0][VEL_W-1:0] in_vel,
  input  bbpv_cmd_t               cmd,
  output bbpv_sts_t               sts,
  output logic [DRV_W-1:0]        out_drive,
  output logic                    out_full,
  output logic                    out_brake,
  output logic [SPD_W-1:0]        out_speed
);

  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd3;

  localparam logic signed [59:0] LIM_HI = 60'(VOLT_LIMIT);
  localparam logic signed [59:0] LIM_LO = -60'(VOLT_LIMIT);

  function automatic logic [31:0] sat32(input logic [33:0] x);
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) return x[31:0];
    else if (x[33]) return 32'h8000_0000;
    else return 32'h7FFF_FFFF;
  endfunction

  // configuration
  logic [CNT_W-1:0] active_r;
  logic [CFG_W-1:0] in_rcp_r, tgt_rcp_r, kv_r, kp_r, ki_r, margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= CNT_W'(4);
      in_rcp_r  <= CFG_W'(27962);
      tgt_rcp_r <= CFG_W'(27962);
      kv_r      <= '0;
      kp_r      <= '0;
      ki_r      <= '0;
      margin_r  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE:  active_r  <= cfg_data[CNT_W-1:0];
        REG_IN_RCP:  in_rcp_r  <= cfg_data;
        REG_TGT_RCP: tgt_rcp_r <= cfg_data;
        REG_KV:      kv_r      <= cfg_data;
        REG_KP:      kp_r      <= cfg_data;
        REG_KI:      ki_r      <= cfg_data;
        REG_MARGIN:  margin_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured tick
  logic [TGT_W-1:0]              tgt_in_r;
  logic [NUM_VEL-1:0][VEL_W-1:0] vel_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tgt_in_r <= in_target;
      vel_r    <= in_vel;
    end
  end

  // average of active readings, truncated toward zero
  logic [CNT_W-1:0]  n_sat;
  logic signed [9:0] vsum;
  logic [9:0]        mag;
  logic [19:0]       q3_prod;
  logic [9:0]        q3, r3;
  logic [9:0]        quot;
  logic [15:0]       frac;
  logic [25:0]       mag_q;
  logic [26:0]       avg_nxt;
  logic [26:0]       avg_r;

  always_comb begin
    if (active_r == '0) n_sat = CNT_W'(1);
    else if (active_r > CNT_W'(MOTOR_LIMIT)) n_sat = CNT_W'(MOTOR_LIMIT);
    else n_sat = active_r;

    vsum = '0;
    for (int i = 0; i < NUM_VEL; i++) begin
      if (i < int'(n_sat)) vsum = vsum + {{2{vel_r[i][VEL_W-1]}}, vel_r[i]};
    end
    mag = vsum[9] ? 10'(-vsum) : 10'(vsum);

    // divide by three through the reciprocal 683/2048, exact below 2048, so for every 10-bit magnitude
    q3_prod = mag * 10'd683;
    q3      = {1'b0, q3_prod[19:11]};
    r3      = mag - {q3[8:0], 1'b0} - q3;

    case (n_sat)
      3'd2: begin
        quot = {1'b0, mag[9:1]};
        frac = {mag[0], 15'b0};
      end
      3'd3: begin
        quot = q3;
        case (r3[1:0])
          2'd1:    frac = 16'd21845;
          2'd2:    frac = 16'd43690;
          default: frac = 16'd0;
        endcase
      end
      3'd4: begin
        quot = {2'b0, mag[9:2]};
        frac = {mag[1:0], 14'b0};
      end
      default: begin
        quot = mag;
        frac = '0;
      end
    endcase

    mag_q   = {quot, 16'b0} + {10'b0, frac};
    avg_nxt = vsum[9] ? -{1'b0, mag_q} : {1'b0, mag_q};
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_en) avg_r <= avg_nxt;
  end

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] prod_r;
  logic signed [58:0] meas_sh, ema_sh, tgt_sh;
  logic [SPD_W-1:0]   speed_r;
  logic [29:0]        target_r;
  logic [31:0]        err_r;
  logic [31:0]        sum_r;
  logic [1:0]         sign_r;
  logic [33:0]        diff;

  assign meas_sh = prod_r >>> 24;
  assign ema_sh  = prod_r >>> 16;
  assign tgt_sh  = prod_r >>> 8;
  assign diff    = meas_sh[33:0] - {{2{speed_r[31]}}, speed_r};

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_MEAS: begin
        mul_a = {{7{avg_r[26]}}, avg_r};
        mul_b = {1'b0, in_rcp_r};
      end
      MUL_EMA: begin
        mul_a = diff;
        mul_b = 25'(ALPHA_Q16);
      end
      MUL_TGT: begin
        mul_a = {{21{tgt_in_r[TGT_W-1]}}, tgt_in_r};
        mul_b = {1'b0, tgt_rcp_r};
      end
      MUL_KV: begin
        mul_a = {{4{target_r[29]}}, target_r};
        mul_b = {1'b0, kv_r};
      end
      MUL_KP: begin
        mul_a = {{2{err_r[31]}}, err_r};
        mul_b = {1'b0, kp_r};
      end
      MUL_KI: begin
        mul_a = {{2{sum_r[31]}}, sum_r};
        mul_b = {1'b0, ki_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
  end

  // ema, target and error
  logic [33:0] ema_w;
  logic [33:0] err_w;

  assign ema_w = {{2{speed_r[31]}}, speed_r} + ema_sh[33:0];
  assign err_w = {{4{tgt_sh[29]}}, tgt_sh[29:0]} - {{2{speed_r[31]}}, speed_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
    end else if (cmd.ema_en) begin
      speed_r <= sat32(ema_w);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tgt_en) begin
      target_r <= tgt_sh[29:0];
      err_r    <= sat32(err_w);
    end
  end

  // bang decision and integral update
  logic signed [33:0] err_x, margin_x;
  logic [33:0]        sum_w;
  logic [31:0]        sum_sat;
  logic [32:0]        sum_adj;
  logic               err_pos;
  logic [1:0]         sign_now;

  assign err_x    = {{2{err_r[31]}}, err_r};
  assign margin_x = {10'b0, margin_r};
  assign sts.bang = err_x > margin_x;
  assign err_pos  = !err_r[31] && (err_r != '0);
  assign sign_now = err_pos ? SIGN_POS : (err_r[31] ? SIGN_NEG : SIGN_ZERO);
  assign sum_w    = {{2{sum_r[31]}}, sum_r} + {{2{err_r[31]}}, err_r};
  assign sum_sat  = sat32(sum_w);
  // halving rounds toward zero
  assign sum_adj  = {sum_sat[31], sum_sat} + {32'b0, sum_sat[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      sign_r <= SIGN_ZERO;
    end else if (cmd.dec_en && !sts.bang) begin
      sum_r  <= (err_pos && sign_r != SIGN_POS) ? sum_adj[32:1] : sum_sat;
      sign_r <= sign_now;
    end
  end

  // power accumulation and clamp
  logic signed [59:0] acc_r;
  logic signed [59:0] prod_x;
  logic signed [59:0] pw;
  logic [DRV_W-1:0]   drive_r;
  logic               full_r;

  assign prod_x = {prod_r[58], prod_r};
  assign pw     = acc_r >>> 16;

  always_ff @(posedge clk) begin
    if (cmd.acc_load) acc_r <= prod_x;
    else if (cmd.acc_add) acc_r <= acc_r + prod_x;
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_en) begin
      full_r <= sts.bang;
      if (sts.bang) drive_r <= DRV_W'(VOLT_LIMIT);
    end
    if (cmd.clamp_en) begin
      if (pw > LIM_HI) drive_r <= DRV_W'(VOLT_LIMIT);
      else if (pw < LIM_LO) drive_r <= DRV_W'(-VOLT_LIMIT);
      else drive_r <= pw[DRV_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_drive <= drive_r;
      out_full  <= full_r;
      out_brake <= (drive_r == '0);
      out_speed <= speed_r;
    end
  end

  // the integral moves only on a decision cycle
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.dec_en |=> $stable(sum_r))
    else $error("integral changed outside a decision");

endmodule

>>> hw/rtl/bang_bang_pi_velocity_control.sv
// ----------------------------------------------------------------------------
// bang_bang_pi_velocity_control
// bang-bang velocity controller with feedforward and PI terms, Q16.16
// ----------------------------------------------------------------------------
// One transfer on the input stream is one control tick: a target speed and
// four velocity readings, of which the first active_motors are averaged.
// Each tick gives exactly one result transfer with the drive voltage, the
// full-drive and brake flags and the updated filtered speed. The controller
// steps one shared 34x25 signed multiplier through the speed scaling, the
// ema, the target scaling and the three gain products; when the error is
// above the margin, full drive is applied and the gain products are
// skipped. The input is ready again the cycle after the result is loaded.
// The next tick is taken as soon as the previous result sits in the output
// register, so a stalled result costs no throughput until a second result
// is ready. Configuration is written through a plain write port, with no
// read-back; writes to indexes beyond the register list are dropped. There
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module bang_bang_pi_velocity_control
  import bbpv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // target_speed[12:0], velocity_a[20:13], velocity_b[28:21],
  // velocity_c[36:29], velocity_d[44:37], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // drive_volts[20:0], filtered_speed[52:21], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // full_drive[0], brake_request[1]
  output logic [OUT_TUSER_W-1:0] out_tuser,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  bbpv_cmd_t cmd;
  bbpv_sts_t sts;

  logic [NUM_VEL-1:0][VEL_W-1:0] vel;
  logic [DRV_W-1:0]              drive;
  logic                          full;
  logic                          brake;
  logic [SPD_W-1:0]              speed;

  // unpack the readings, motor a first
  always_comb begin
    for (int i = 0; i < NUM_VEL; i++) begin
      vel[i] = in_tdata[TGT_W + i*VEL_W +: VEL_W];
    end
  end

  bbpv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bbpv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_target (in_tdata[TGT_W-1:0]),
    .in_vel    (vel),
    .cmd       (cmd),
    .sts       (sts),
    .out_drive (drive),
    .out_full  (full),
    .out_brake (brake),
    .out_speed (speed)
  );

  // pack the result, pad bits held at zero
  assign out_tdata = {{(OUT_TDATA_W - DRV_W - SPD_W){1'b0}}, speed, drive};
  assign out_tuser = {brake, full};

  // full drive always presents the positive limit
  a_full_is_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> $signed(out_tdata[DRV_W-1:0]) == VOLT_LIMIT)
    else $error("full drive without the voltage limit");

  // presented drive stays within the clamp
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[DRV_W-1:0]) <= VOLT_LIMIT &&
                    $signed(out_tdata[DRV_W-1:0]) >= -VOLT_LIMIT))
    else $error("drive outside the clamp");

endmodule

>>> tb/sv/bbpv_tick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpv_tick_checker
// follows the configuration port and the input stream, works out the result
// of every control tick and compares it with the result stream
// ----------------------------------------------------------------------------
module bbpv_tick_checker
  import bbpv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd3
  } err_sign_t;

  typedef struct packed {
    logic [DRV_W-1:0] drive_volts;
    logic             full_drive;
    logic             brake_request;
    logic [SPD_W-1:0] filtered_speed;
  } tick_result_t;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;

  tick_result_t awaited_results [$];
  tick_result_t got, want;

  // register copies
  logic [CNT_W-1:0] motors_cfg;
  longint in_rcp, tgt_rcp, kv, kp, ki, margin;

  // controller state
  longint speed_avg, err_sum;
  logic [1:0] last_sign;

  function automatic longint sat32(input longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic tick_result_t run_control_tick(input logic [IN_TDATA_W-1:0] d);
    longint tgt_in, vel, vel_sum, n, avg, meas, tgt, err, power;
    err_sign_t sign_now;
    tick_result_t r;
    int i;
    tgt_in = longint'($signed(d[TGT_W-1:0]));
    n = longint'(motors_cfg);
    if (n < 1) n = 1;
    if (n > MOTOR_LIMIT) n = MOTOR_LIMIT;
    vel_sum = 0;
    for (i = 0; i < n; i++) begin
      vel = longint'($signed(d[TGT_W + i*VEL_W +: VEL_W]));
      vel_sum += vel;
    end
    // division truncates toward zero, the shifts floor
    avg = (vel_sum * 65536) / n;
    meas = (avg * in_rcp) >>> 24;
    speed_avg = sat32(speed_avg + (((meas - speed_avg) * ALPHA_Q16) >>> 16));
    tgt = (tgt_in * tgt_rcp) >>> 8;
    err = sat32(tgt - speed_avg);
    if (err > margin) begin
      power = VOLT_LIMIT;
      r.full_drive = 1'b1;
    end else begin
      sign_now = (err > 0) ? SIGN_POS : ((err < 0) ? SIGN_NEG : SIGN_ZERO);
      err_sum = sat32(err_sum + err);
      // integral halved on turning positive
      if (sign_now == SIGN_POS && last_sign != SIGN_POS) err_sum = err_sum / 2;
      last_sign = sign_now;
      power = (kv * tgt + kp * err + ki * err_sum) >>> 16;
      if (power > VOLT_LIMIT) power = VOLT_LIMIT;
      if (power < -VOLT_LIMIT) power = -VOLT_LIMIT;
      r.full_drive = 1'b0;
    end
    r.drive_volts    = power[DRV_W-1:0];
    r.brake_request  = (power == 0);
    r.filtered_speed = speed_avg[SPD_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      motors_cfg = 3'd4;
      in_rcp     = 27962;
      tgt_rcp    = 27962;
      kv         = 0;
      kp         = 0;
      ki         = 0;
      margin     = 16777215;
      speed_avg  = 0;
      err_sum    = 0;
      last_sign  = SIGN_ZERO;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE:  motors_cfg = cfg_data[CNT_W-1:0];
          REG_IN_RCP:  in_rcp     = longint'(cfg_data);
          REG_TGT_RCP: tgt_rcp    = longint'(cfg_data);
          REG_KV:      kv         = longint'(cfg_data);
          REG_KP:      kp         = longint'(cfg_data);
          REG_KI:      ki         = longint'(cfg_data);
          REG_MARGIN:  margin     = longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) awaited_results.push_back(run_control_tick(in_tdata));
      if (out_tvalid && out_tready) begin
        got.drive_volts    = out_tdata[DRV_W-1:0];
        got.filtered_speed = out_tdata[DRV_W +: SPD_W];
        got.full_drive     = out_tuser[0];
        got.brake_request  = out_tuser[1];
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: drive %0d full %0b brake %0b speed %0d",
                     $signed(got.drive_volts), got.full_drive, got.brake_request,
                     $signed(got.filtered_speed));
        end else begin
          want = awaited_results.pop_front();
          if (got.drive_volts !== want.drive_volts || got.full_drive !== want.full_drive ||
              got.brake_request !== want.brake_request ||
              got.filtered_speed !== want.filtered_speed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: drive %0d/%0d full %0b/%0b brake %0b/%0b speed %0d/%0d",
                       $signed(want.drive_volts), $signed(got.drive_volts),
                       want.full_drive, got.full_drive, want.brake_request, got.brake_request,
                       $signed(want.filtered_speed), $signed(got.filtered_speed));
          end
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

>>> tb/sv/bang_bang_pi_velocity_control_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bang_bang_pi_velocity_control_tb
// drives control ticks and register settings into the velocity controller;
// a checker beside the block predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module bang_bang_pi_velocity_control_tb;
  import bbpv_pkg::*;

  // the one index past the register list, writes there must be dropped
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  localparam int STALL_LIMIT   = 4000; // cycles without any transfer or register write
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int PHASES        = 12;
  localparam int PHASE_TICKS   = 110;
  localparam int SETTLE_CYCLES = 32;   // idle time before the final verdict

  typedef enum int {
    CFG_DIRECTED,
    CFG_FULL_SCALE,
    CFG_ZERO_SCALE,
    CFG_RANDOM
  } cfg_kind_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [IDX_W-1:0]       cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_data   = '0;

  int mismatches;
  int outstanding;

  // idling controls
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_asks       = 0;
  int hold_served     = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  // slowly moving operating point for the random ticks
  int held_target = 0;
  int held_vel    = 0;

  bang_bang_pi_velocity_control dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bbpv_tick_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for;
  // the hold-off is counted here so the sender keeps offering ticks meanwhile
  always @(negedge clk) begin
    if (hold_left == 0 && hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: any transfer or register write counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // target_speed lowest, then the four velocities, zero pad on top
  function automatic logic [IN_TDATA_W-1:0] pack_tick(input int tgt, input int va,
                                                      input int vb, input int vc,
                                                      input int vd);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[TGT_W-1:0]               = tgt[TGT_W-1:0];
    w[TGT_W +: VEL_W]          = va[VEL_W-1:0];
    w[TGT_W + VEL_W +: VEL_W]  = vb[VEL_W-1:0];
    w[TGT_W + 2*VEL_W +: VEL_W] = vc[VEL_W-1:0];
    w[TGT_W + 3*VEL_W +: VEL_W] = vd[VEL_W-1:0];
    return w;
  endfunction

  function automatic int any_target();
    case ($urandom_range(7))
      0:       return -4096;
      1:       return 4095;
      default: return int'($urandom_range(8191)) - 4096;
    endcase
  endfunction

  function automatic int any_vel();
    return int'($urandom_range(200)) - 100;
  endfunction

  // mostly runs of a held target with jittered readings, so the filter
  // settles and the error changes sign; a few ticks are pure noise
  function automatic logic [IN_TDATA_W-1:0] random_tick();
    int tgt;
    int v [4];
    int i;
    if ($urandom_range(99) < 5) begin
      tgt = any_target();
      for (i = 0; i < 4; i++) v[i] = any_vel();
    end else begin
      if ($urandom_range(7) == 0) held_target = any_target();
      if ($urandom_range(9) == 0) held_vel = any_vel();
      tgt = held_target;
      if ($urandom_range(4) == 0)
        tgt = clip(held_target + int'($urandom_range(32)) - 16, -4096, 4095);
      for (i = 0; i < 4; i++)
        v[i] = clip(held_vel + int'($urandom_range(24)) - 12, -100, 100);
    end
    return pack_tick(tgt, v[0], v[1], v[2], v[3]);
  endfunction

  function automatic logic [CFG_W-1:0] any_recip();
    case ($urandom_range(4))
      0:       return CFG_W'($urandom_range(24'hFFFFFF, 1));
      1:       return CFG_W'(27962 + $urandom_range(2000));
      2:       return 24'd1;
      3:       return 24'hFFFFFF;
      default: return CFG_W'($urandom_range(1 << 22, 1 << 16));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] any_gain();
    case ($urandom_range(5))
      0:       return '0;
      1, 2:    return CFG_W'($urandom_range(1 << 18));
      3:       return CFG_W'($urandom_range(1 << 20));
      4:       return CFG_W'($urandom);
      default: return 24'hFFFFFF;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] any_margin();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return CFG_W'($urandom_range(1 << 20));
      default: return CFG_W'($urandom_range(1 << 18));
    endcase
  endfunction

  // one tick on the input stream, with random idle cycles ahead of it
  task automatic send_tick(input logic [IN_TDATA_W-1:0] word);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'({$urandom, $urandom}); // junk that must not be taken
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // sender stops until every tick in flight has delivered its result
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic load_config(input cfg_kind_t kind, input int phase);
    logic [CFG_W-1:0] motors, in_r, tgt_r, g_v, g_p, g_i, marg;
    case (kind)
      CFG_DIRECTED: begin
        // unity feedforward, margin of 3.0 on the error (Q16.16)
        motors = 24'd4;
        in_r   = 24'd27962;
        tgt_r  = 24'd27962;
        g_v    = 24'h010000;
        g_p    = 24'h040000;
        g_i    = 24'h001000;
        marg   = 24'h030000;
      end
      CFG_FULL_SCALE: begin
        // motor count 7 saturates to the limit
        motors = 24'hFFFFFF;
        in_r   = 24'hFFFFFF;
        tgt_r  = 24'hFFFFFF;
        g_v    = 24'hFFFFFF;
        g_p    = 24'hFFFFFF;
        g_i    = 24'hFFFFFF;
        marg   = 24'hFFFFFF;
      end
      CFG_ZERO_SCALE: begin
        // motor count 0 counts as one
        motors = '0;
        in_r   = 24'd1;
        tgt_r  = 24'd1;
        g_v    = '0;
        g_p    = '0;
        g_i    = '0;
        marg   = '0;
      end
      default: begin
        // motor counts 0 to 6 come round; upper bits carry junk
        motors = {(CFG_W-CNT_W)'($urandom), CNT_W'(phase)};
        in_r   = any_recip();
        tgt_r  = any_recip();
        g_v    = any_gain();
        g_p    = any_gain();
        g_i    = any_gain();
        marg   = any_margin();
      end
    endcase
    write_reg(REG_ACTIVE, motors);
    write_reg(REG_IN_RCP, in_r);
    write_reg(REG_TGT_RCP, tgt_r);
    write_reg(REG_KV, g_v);
    write_reg(REG_KP, g_p);
    write_reg(REG_KI, g_i);
    write_reg(REG_MARGIN, marg);
    write_reg(REG_NONE, CFG_W'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase;
    int k;
    cfg_kind_t kind;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: all gains zero, so every tick should ask for the brake
    send_tick(pack_tick(0, 0, 0, 0, 0));
    send_tick(pack_tick(4095, 100, 100, 100, 100));
    send_tick(pack_tick(-4096, -100, -100, -100, -100));

    wait_idle();
    load_config(CFG_DIRECTED, 0);
    // large positive error takes the bang-bang branch
    send_tick(pack_tick(4095, 100, 100, 100, 100));
    send_tick(pack_tick(4095, -100, -100, -100, -100));
    // large negative demand clamps at the lower limit
    send_tick(pack_tick(-4096, 100, 100, 100, 100));
    send_tick(pack_tick(0, 0, 0, 0, 0));
    // negative error run, then a turn positive halves the integral
    send_tick(pack_tick(-1000, 0, 0, 0, 0));
    send_tick(pack_tick(-1000, 0, 0, 0, 0));
    send_tick(pack_tick(-1000, 0, 0, 0, 0));
    send_tick(pack_tick(1000, 0, 0, 0, 0));
    send_tick(pack_tick(1000, 0, 0, 0, 0));
    send_tick(pack_tick(1, 1, -1, 99, -99));
    send_tick(pack_tick(-1, -99, 99, -1, 1));
    send_tick(pack_tick(0, 100, -100, 100, -100));

    wait_idle();
    load_config(CFG_ZERO_SCALE, 0);
    send_tick(pack_tick(2000, 50, -100, 100, 100));
    send_tick(pack_tick(-2000, -77, 100, 100, 100));
    send_tick(pack_tick(4095, 100, -100, -100, -100));

    wait_idle();
    load_config(CFG_FULL_SCALE, 0);
    send_tick(pack_tick(4095, 100, 100, 100, 100));
    send_tick(pack_tick(-4096, -100, -100, -100, -100));
    send_tick(pack_tick(-4096, 100, 100, 100, 100));

    // random phases, each with its own settings and idling pattern
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      kind = (phase == 3) ? CFG_FULL_SCALE : ((phase == 7) ? CFG_ZERO_SCALE : CFG_RANDOM);
      load_config(kind, phase);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin sender_idle_pct = 65; recv_stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct <= 65; end
        default: begin sender_idle_pct = 38; recv_stall_pct <= 38; end
      endcase
      for (k = 0; k < PHASE_TICKS; k++) begin
        // long hold-off while ticks keep coming, so the input backs up
        if (phase == 4 && k == 20) hold_asks <= hold_asks + 1;
        send_tick(random_tick());
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
